>>> rtl/tfn_pkg.sv
// Package with the shared widths, pipeline struct and helper function of the face normal block.
package tfn_pkg;

  localparam int unsigned CoordBits  = 16;
  localparam int unsigned EdgeBits   = CoordBits + 1;
  localparam int unsigned ProdBits   = 2 * EdgeBits;
  localparam int unsigned CrossBits  = ProdBits + 1;
  localparam int unsigned MagBits    = CrossBits;
  localparam int unsigned NormBits   = 30;
  localparam int unsigned SumBits    = 2 * NormBits + 2;
  localparam int unsigned LenBits    = NormBits + 1;
  localparam int unsigned FracBits   = 14;
  localparam int unsigned NumBits    = NormBits + FracBits + 1;
  localparam int unsigned QuotBits   = FracBits + 3;
  localparam int unsigned OutBits    = 16;
  localparam int unsigned ShiftBits  = 6;
  localparam int unsigned SqrtSteps  = LenBits;
  localparam int unsigned DivSteps   = QuotBits;
  localparam int unsigned InDataBits = 9 * CoordBits;
  localparam int unsigned OutDataBits = 3 * OutBits;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [EdgeBits-1:0]  edge_t;
  typedef logic signed [CrossBits-1:0] cross_t;
  typedef logic [MagBits-1:0]          mag_t;
  typedef logic [NormBits-1:0]         norm_t;
  typedef logic [SumBits-1:0]          sum_t;
  typedef logic [LenBits-1:0]          len_t;
  typedef logic [NumBits-1:0]          num_t;
  typedef logic [QuotBits-1:0]         quot_t;
  typedef logic signed [OutBits-1:0]   out_t;

  // Side data that travels with a triangle through the length and divide stages.
  typedef struct packed {
    norm_t [2:0] mag;
    logic  [2:0] neg;
    logic        degen;
  } vec_t;

  // Number of leading zeros of a magnitude word.
  function automatic logic [ShiftBits-1:0] lzc(input mag_t v);
    logic [ShiftBits-1:0] n;
    logic                 hit;
    n   = ShiftBits'(MagBits);
    hit = 1'b0;
    for (int i = MagBits - 1; i >= 0; i--) begin
      if (v[i] && !hit) begin
        n   = ShiftBits'(MagBits - 1 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

>>> rtl/tfn_cross.sv
// Edge differences, cross product and sign/magnitude split, three register stages.
module tfn_cross (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  tfn_pkg::coord_t [8:0] coord_i,
  output logic              valid_o,
  output tfn_pkg::mag_t [2:0] mag_o,
  output logic [2:0]        neg_o
);

  logic [2:0] valid_q;
  tfn_pkg::edge_t [2:0] e1_q, e2_q;
  logic signed [tfn_pkg::ProdBits-1:0] p_q [6];
  tfn_pkg::mag_t [2:0] mag_q;
  logic [2:0] neg_q;
  tfn_pkg::cross_t [2:0] cr;

  always_comb begin
    cr[0] = tfn_pkg::CrossBits'(p_q[0]) - tfn_pkg::CrossBits'(p_q[1]);
    cr[1] = tfn_pkg::CrossBits'(p_q[2]) - tfn_pkg::CrossBits'(p_q[3]);
    cr[2] = tfn_pkg::CrossBits'(p_q[4]) - tfn_pkg::CrossBits'(p_q[5]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= tfn_pkg::EdgeBits'(coord_i[i]) - tfn_pkg::EdgeBits'(coord_i[3+i]);
        e2_q[i] <= tfn_pkg::EdgeBits'(coord_i[i]) - tfn_pkg::EdgeBits'(coord_i[6+i]);
      end
      p_q[0] <= e1_q[1] * e2_q[2];
      p_q[1] <= e1_q[2] * e2_q[1];
      p_q[2] <= e1_q[2] * e2_q[0];
      p_q[3] <= e1_q[0] * e2_q[2];
      p_q[4] <= e1_q[0] * e2_q[1];
      p_q[5] <= e1_q[1] * e2_q[0];
      for (int i = 0; i < 3; i++) begin
        neg_q[i] <= cr[i][tfn_pkg::CrossBits-1];
        mag_q[i] <= cr[i][tfn_pkg::CrossBits-1] ? tfn_pkg::MagBits'(-cr[i])
                                                 : tfn_pkg::MagBits'(cr[i]);
      end
    end
  end

  assign valid_o = valid_q[2];
  assign mag_o   = mag_q;
  assign neg_o   = neg_q;

endmodule

>>> rtl/tfn_norm.sv
// Normalizing shift and sum of squares, three register stages.
module tfn_norm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  tfn_pkg::mag_t [2:0] mag_i,
  input  logic [2:0]          neg_i,
  output logic                valid_o,
  output tfn_pkg::vec_t       vec_o,
  output tfn_pkg::sum_t       sum_o
);

  localparam int unsigned Target = tfn_pkg::MagBits - tfn_pkg::NormBits;

  logic [2:0] valid_q;
  tfn_pkg::mag_t [2:0] m1_q;
  logic [2:0] n1_q, n2_q, n3_q;
  logic [tfn_pkg::ShiftBits-1:0] lz_q;
  logic degen_q, d2_q, d3_q;
  tfn_pkg::norm_t [2:0] m2_q, m3_q;
  tfn_pkg::sum_t [2:0] sq_q;
  tfn_pkg::mag_t mx;
  logic [tfn_pkg::ShiftBits-1:0] lz;
  tfn_pkg::mag_t [2:0] sh;

  always_comb begin
    mx = mag_i[0];
    if (mag_i[1] > mx) mx = mag_i[1];
    if (mag_i[2] > mx) mx = mag_i[2];
    lz = tfn_pkg::lzc(mx);
    for (int i = 0; i < 3; i++) begin
      if (lz_q >= tfn_pkg::ShiftBits'(Target)) begin
        sh[i] = m1_q[i] << (lz_q - tfn_pkg::ShiftBits'(Target));
      end else begin
        sh[i] = m1_q[i] >> (tfn_pkg::ShiftBits'(Target) - lz_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q    <= mag_i;
      n1_q    <= neg_i;
      lz_q    <= lz;
      degen_q <= (mx == '0);
      for (int i = 0; i < 3; i++) m2_q[i] <= tfn_pkg::NormBits'(sh[i]);
      n2_q <= n1_q;
      d2_q <= degen_q;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= tfn_pkg::SumBits'(m2_q[i]) * tfn_pkg::SumBits'(m2_q[i]);
      end
      m3_q <= m2_q;
      n3_q <= n2_q;
      d3_q <= d2_q;
    end
  end

  assign valid_o     = valid_q[2];
  assign vec_o.mag   = m3_q;
  assign vec_o.neg   = n3_q;
  assign vec_o.degen = d3_q;
  assign sum_o       = sq_q[0] + sq_q[1] + sq_q[2];

endmodule

>>> rtl/tfn_sqrt.sv
// Pipelined restoring square root, one result bit per stage.
module tfn_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  tfn_pkg::sum_t       sum_i,
  input  tfn_pkg::vec_t       vec_i,
  output logic                valid_o,
  output tfn_pkg::len_t       len_o,
  output tfn_pkg::vec_t       vec_o
);

  localparam int unsigned N = tfn_pkg::SqrtSteps;
  localparam int unsigned RemBits = tfn_pkg::LenBits + 2;

  logic [N:0]            valid_q;
  tfn_pkg::sum_t         x_q   [N+1];
  logic [RemBits-1:0]    rem_q [N+1];
  tfn_pkg::len_t         root_q[N+1];
  tfn_pkg::vec_t         vec_q [N+1];

  always_comb begin
    x_q[0]    = sum_i;
    rem_q[0]  = '0;
    root_q[0] = '0;
    vec_q[0]  = vec_i;
  end
  assign valid_q[0] = valid_i;

  for (genvar s = 0; s < N; s++) begin : g_step
    logic [RemBits-1:0] r, t;
    always_comb begin
      r = {rem_q[s][RemBits-3:0], x_q[s][tfn_pkg::SumBits-1 -: 2]};
      t = {root_q[s], 2'b01};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[s+1] <= valid_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[s+1]   <= x_q[s] << 2;
        vec_q[s+1] <= vec_q[s];
        if (r >= t) begin
          rem_q[s+1]  <= r - t;
          root_q[s+1] <= {root_q[s][tfn_pkg::LenBits-2:0], 1'b1};
        end else begin
          rem_q[s+1]  <= r;
          root_q[s+1] <= {root_q[s][tfn_pkg::LenBits-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = valid_q[N];
  assign len_o   = root_q[N];
  assign vec_o   = vec_q[N];

endmodule

>>> rtl/tfn_div.sv
// Three pipelined restoring dividers that scale the magnitudes by the length.
module tfn_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  tfn_pkg::len_t       len_i,
  input  tfn_pkg::vec_t       vec_i,
  output logic                valid_o,
  output tfn_pkg::out_t [2:0] normal_o,
  output logic                degen_o
);

  localparam int unsigned N = tfn_pkg::DivSteps;
  localparam int unsigned RBits = tfn_pkg::LenBits + 1;

  logic [N+1:0]        valid_q;
  tfn_pkg::len_t       len_q [N+2];
  tfn_pkg::num_t [2:0] num_q [N+2];
  logic [RBits-1:0]    rem_q [N+2][3];
  tfn_pkg::quot_t      quo_q [N+2][3];
  logic [2:0]          neg_q [N+2];
  logic                dg_q  [N+2];
  tfn_pkg::out_t [2:0] res_q;
  logic                dgo_q;
  logic                vo_q;

  always_comb begin
    valid_q[0] = valid_i;
    len_q[0]   = len_i;
    neg_q[0]   = vec_i.neg;
    dg_q[0]    = vec_i.degen;
    for (int i = 0; i < 3; i++) begin
      // Numerator is mag * 2^frac + floor(len / 2).
      num_q[0][i] = (tfn_pkg::NumBits'(vec_i.mag[i]) << tfn_pkg::FracBits)
                  + tfn_pkg::NumBits'(len_i >> 1);
      rem_q[0][i] = '0;
      quo_q[0][i] = '0;
    end
  end

  // The first stage loads the top bits as the remainder; they stay below the length.
  localparam int unsigned LowBits = N;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q[1] <= 1'b0;
    else if (en_i) valid_q[1] <= valid_q[0];
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q[1] <= len_q[0];
      neg_q[1] <= neg_q[0];
      dg_q[1]  <= dg_q[0];
      for (int i = 0; i < 3; i++) begin
        rem_q[1][i] <= RBits'(num_q[0][i] >> LowBits);
        num_q[1][i] <= num_q[0][i] << (tfn_pkg::NumBits - LowBits);
        quo_q[1][i] <= '0;
      end
    end
  end

  for (genvar s = 1; s <= N; s++) begin : g_step
    logic [RBits-1:0] r [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r[i] = {rem_q[s][i][RBits-2:0], num_q[s][i][tfn_pkg::NumBits-1]};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) valid_q[s+1] <= 1'b0;
      else if (en_i) valid_q[s+1] <= valid_q[s];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        len_q[s+1] <= len_q[s];
        neg_q[s+1] <= neg_q[s];
        dg_q[s+1]  <= dg_q[s];
        for (int i = 0; i < 3; i++) begin
          num_q[s+1][i] <= num_q[s][i] << 1;
          if (r[i] >= RBits'(len_q[s])) begin
            rem_q[s+1][i] <= r[i] - RBits'(len_q[s]);
            quo_q[s+1][i] <= {quo_q[s][i][tfn_pkg::QuotBits-2:0], 1'b1};
          end else begin
            rem_q[s+1][i] <= r[i];
            quo_q[s+1][i] <= {quo_q[s][i][tfn_pkg::QuotBits-2:0], 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (en_i) vo_q <= valid_q[N+1];
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dgo_q <= dg_q[N+1];
      for (int i = 0; i < 3; i++) begin
        if (dg_q[N+1]) begin
          res_q[i] <= '0;
        end else if (neg_q[N+1][i]) begin
          res_q[i] <= (quo_q[N+1][i] > tfn_pkg::QuotBits'(32768)) ? tfn_pkg::OutBits'(-32768)
                    : tfn_pkg::OutBits'(-quo_q[N+1][i]);
        end else begin
          res_q[i] <= (quo_q[N+1][i] > tfn_pkg::QuotBits'(32767)) ? tfn_pkg::OutBits'(32767)
                    : tfn_pkg::OutBits'(quo_q[N+1][i]);
        end
      end
    end
  end

  assign valid_o  = vo_q;
  assign normal_o = res_q;
  assign degen_o  = dgo_q;

endmodule

>>> rtl/triangle_face_normal.sv
// Top level of the pipelined triangle face normal unit.
//   channel  dir  contents
//   s_axis   in   one triangle: three vertices, signed Q8.8
//   m_axis   out  unit normal in signed Q1.14 and a degenerate flag
// One triangle enters each cycle while the output is not stalled; it passes the cross
// product, the scaling and squares, the bit-per-stage square root and the divider
// chain with its entry and output registers, in that order.
// Reset clears only the valid bits of the stages.
// A stall at the output freezes the whole pipeline, so no word is lost or repeated.
module triangle_face_normal (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from the lowest bit up
  input  logic [tfn_pkg::InDataBits-1:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // normal_x, normal_y, normal_z from the lowest bit up
  output logic [tfn_pkg::OutDataBits-1:0] m_axis_tdata,
  // degenerate
  output logic         m_axis_tuser
);

  logic en;
  logic v_cr, v_nm, v_sq, v_dv;
  tfn_pkg::coord_t [8:0] coord;
  tfn_pkg::mag_t [2:0] mag;
  logic [2:0] neg;
  tfn_pkg::vec_t vec_nm, vec_sq;
  tfn_pkg::sum_t sum;
  tfn_pkg::len_t len;
  tfn_pkg::out_t [2:0] normal;
  logic degen;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign coord         = s_axis_tdata;

  tfn_cross u_cross (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid), .coord_i(coord),
    .valid_o(v_cr), .mag_o(mag), .neg_o(neg)
  );
  tfn_norm u_norm (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_cr), .mag_i(mag), .neg_i(neg),
    .valid_o(v_nm), .vec_o(vec_nm), .sum_o(sum)
  );
  tfn_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_nm), .sum_i(sum), .vec_i(vec_nm),
    .valid_o(v_sq), .len_o(len), .vec_o(vec_sq)
  );
  tfn_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_sq), .len_i(len), .vec_i(vec_sq),
    .valid_o(v_dv), .normal_o(normal), .degen_o(degen)
  );

  assign m_axis_tvalid = v_dv;
  assign m_axis_tdata  = normal;
  assign m_axis_tuser  = degen;

  // A degenerate word always carries a zero normal.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("degenerate word with non-zero normal");
  // While stalled the result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  // Input is taken exactly when the pipeline advances.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready does not follow pipeline advance");

endmodule
